// File: sv/cst_pkg.sv
`timescale 1ns / 1ps
package cst_pkg;

   localparam int PT_W     = 24;
   localparam int TEN_W    = 8;
   localparam int CTRL_W   = 34;   // control point, q16.16 plus chord offset headroom
   localparam int DOTS_DEF = 10;
   localparam int QDEPTH   = 4;

   localparam logic [TEN_W-1:0] TEN_RESET = 8'd102;
   localparam logic signed [PT_W-1:0] PT_MAX = 24'sh7fffff;
   localparam logic signed [PT_W-1:0] PT_MIN = -24'sh800000;

   typedef logic signed [PT_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   // one curve segment: outer neighbours p1/p4, ends p2/p3
   typedef struct packed {
      point_type p1;
      point_type p2;
      point_type p3;
      point_type p4;
      logic      brk;
      logic      last;
   } seg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: sv/cst_ifs.sv
`timescale 1ns / 1ps
interface cst_req_if import cst_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type x;
   coord_type y;
   coord_type z;
   logic      strand_end;

   modport source (output valid, x, y, z, strand_end, input ready);
   modport sink (input valid, x, y, z, strand_end, output ready);
endinterface

interface cst_rsp_if import cst_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   coord_type out_z;
   logic      is_break;
   logic      last;

   modport source (output valid, out_x, out_y, out_z, is_break, last, input ready);
   modport sink (input valid, out_x, out_y, out_z, is_break, last, output ready);
endinterface

interface cst_csr_if import cst_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [TEN_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// File: sv/cst_front.sv
`timescale 1ns / 1ps
module cst_front import cst_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cst_req_if.sink   req_chan,
   input  qstat_type qstat,
   output logic      push,
   output seg_type   push_seg
);

   logic      [1:0] cnt_ff, cnt_in;
   point_type       hist_ff [3];
   point_type       hist_in [3];
   seg_type         pend_ff, pend_in;
   logic            pend_valid_ff, pend_valid_in;

   point_type np;
   logic      accept;
   logic      has_a, has_b;
   seg_type   seg_a, seg_b;

   always_comb begin
      np.x = req_chan.x;
      np.y = req_chan.y;
      np.z = req_chan.z;
      req_chan.ready = !pend_valid_ff && !qstat.full;
      accept = req_chan.valid && req_chan.ready;

      // segment between the two newest held points, this point as outer neighbour
      has_a      = cnt_ff inside {2'd2, 2'd3};
      seg_a.p1   = (cnt_ff == 2'd3) ? hist_ff[2] : hist_ff[1];
      seg_a.p2   = hist_ff[1];
      seg_a.p3   = hist_ff[0];
      seg_a.p4   = np;
      seg_a.brk  = (cnt_ff == 2'd2);
      seg_a.last = !req_chan.strand_end;

      // closing segment of a strand, far neighbour missing
      has_b      = req_chan.strand_end && (cnt_ff != 2'd0);
      seg_b.p1   = (cnt_ff inside {2'd2, 2'd3}) ? hist_ff[1] : hist_ff[0];
      seg_b.p2   = hist_ff[0];
      seg_b.p3   = np;
      seg_b.p4   = np;
      seg_b.brk  = (cnt_ff == 2'd1);
      seg_b.last = 1'b1;

      if (pend_valid_ff) begin
         push     = !qstat.full;
         push_seg = pend_ff;
      end else begin
         push     = accept && (has_a || has_b);
         push_seg = has_a ? seg_a : seg_b;
      end

      pend_in       = accept ? seg_b : pend_ff;
      pend_valid_in = pend_valid_ff;
      if (pend_valid_ff && !qstat.full) begin
         pend_valid_in = 1'b0;
      end else if (accept && has_a && has_b) begin
         pend_valid_in = 1'b1;
      end

      cnt_in = cnt_ff;
      for (int i = 0; i < 3; i++) begin
         hist_in[i] = hist_ff[i];
      end
      if (accept) begin
         if (req_chan.strand_end) begin
            cnt_in = 2'd0;
         end else begin
            cnt_in     = (cnt_ff == 2'd3) ? 2'd3 : cnt_ff + 2'd1;
            hist_in[2] = hist_ff[1];
            hist_in[1] = hist_ff[0];
            hist_in[0] = np;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= 2'd0;
         pend_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         for (int i = 0; i < 3; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule

// File: sv/cst_queue.sv
`timescale 1ns / 1ps
module cst_queue import cst_pkg::*; #(
   parameter int DEPTH = QDEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  seg_type   push_data,
   input  logic      pop,
   output seg_type   pop_data,
   output qstat_type qstat
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0]   LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

   seg_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
      qstat.full  = (count_ff == FULL_CNT);
      qstat.empty = (count_ff == '0);
      pop_data    = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/cst_back.sv
`timescale 1ns / 1ps
module cst_back import cst_pkg::*; #(
   parameter int DOTS = DOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [TEN_W-1:0] tension,
   input  seg_type          head,
   input  qstat_type        qstat,
   output logic             pop,
   cst_rsp_if.source        rsp_chan
);

   localparam int D3   = DOTS * DOTS * DOTS;
   localparam int WW   = $clog2(D3 + 1);
   localparam int KW   = $clog2(DOTS);
   localparam int PW   = WW + CTRL_W + 1;
   localparam int NW   = WW + CTRL_W + 1;
   localparam int UW   = PT_W + WW;
   localparam int TSH  = WW - 4;
   localparam int NTW  = UW - TSH;
   localparam int RW   = 29;
   localparam int EPW  = NTW + RW;
   localparam int PSH  = 31;

   localparam logic [KW-1:0]         K_LAST   = KW'(DOTS - 1);
   localparam logic signed [NW-1:0]  HALF     = NW'(D3 * 128);
   localparam logic signed [NW-1:0]  SPAN     = NW'(D3) <<< (PT_W - 1);
   localparam logic signed [NW-1:0]  NEG_SPAN = -SPAN;
   localparam logic [UW-1:0]         D3_U     = UW'(D3);
   // reciprocal of dots cubed at scale 2^(WW+27), estimate is low by at most one
   localparam longint                RECIP_L  = (longint'(1) <<< (WW + 27)) / D3;
   localparam logic [RW-1:0]         RECIP    = RW'(RECIP_L);

   function automatic coord_type pick(input point_type p, input int a);
      coord_type r;
      case (a)
         0:       r = p.x;
         1:       r = p.y;
         default: r = p.z;
      endcase
      return r;
   endfunction

   // bernstein weights scaled by dots cubed
   logic [WW-1:0] w1_rom [DOTS];
   logic [WW-1:0] w2_rom [DOTS];
   logic [WW-1:0] w3_rom [DOTS];
   logic [WW-1:0] w4_rom [DOTS];

   for (genvar k = 0; k < DOTS; k++) begin : g_wt
      assign w1_rom[k] = WW'((DOTS - k) * (DOTS - k) * (DOTS - k));
      assign w2_rom[k] = WW'(3 * k * (DOTS - k) * (DOTS - k));
      assign w3_rom[k] = WW'(3 * k * k * (DOTS - k));
      assign w4_rom[k] = WW'(k * k * k);
   end

   logic adv;

   // segment issue stage
   logic                     seg_valid_ff, seg_valid_in;
   logic                     brk_pend_ff, brk_pend_in;
   logic                     seg_last_ff, seg_last_in;
   logic [KW-1:0]            k_ff, k_in;
   coord_type                p2_ff [3];
   coord_type                p2_in [3];
   coord_type                p3_ff [3];
   coord_type                p3_in [3];
   logic signed [CTRL_W-1:0] c1_ff [3];
   logic signed [CTRL_W-1:0] c1_in [3];
   logic signed [CTRL_W-1:0] c2_ff [3];
   logic signed [CTRL_W-1:0] c2_in [3];
   logic signed [PT_W:0]     d1 [3];
   logic signed [PT_W:0]     d2 [3];
   logic                     k_end;

   // product stage
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_brk_ff, s1_brk_in;
   logic                 s1_last_ff, s1_last_in;
   logic signed [PW-1:0] m1_ff [3];
   logic signed [PW-1:0] m1_in [3];
   logic signed [PW-1:0] m2_ff [3];
   logic signed [PW-1:0] m2_in [3];
   logic signed [PW-1:0] m3_ff [3];
   logic signed [PW-1:0] m3_in [3];
   logic signed [PW-1:0] m4_ff [3];
   logic signed [PW-1:0] m4_in [3];

   // sum stage
   logic                 s2_valid_ff, s2_valid_in;
   logic                 s2_brk_ff, s2_brk_in;
   logic                 s2_last_ff, s2_last_in;
   logic signed [NW-1:0] sum_ff [3];
   logic signed [NW-1:0] sum_in [3];
   logic signed [NW-1:0] tot [3];

   // range check, offset into the unsigned range
   logic          rc_valid_ff, rc_valid_in;
   logic          rc_brk_ff, rc_brk_in;
   logic          rc_last_ff, rc_last_in;
   logic          rc_hi_ff [3];
   logic          rc_hi_in [3];
   logic          rc_lo_ff [3];
   logic          rc_lo_in [3];
   logic [UW-1:0] rc_num_ff [3];
   logic [UW-1:0] rc_num_in [3];

   // quotient estimate by reciprocal multiplication
   logic            qe_valid_ff, qe_valid_in;
   logic            qe_brk_ff, qe_brk_in;
   logic            qe_last_ff, qe_last_in;
   logic            qe_hi_ff [3];
   logic            qe_hi_in [3];
   logic            qe_lo_ff [3];
   logic            qe_lo_in [3];
   logic [UW-1:0]   qe_num_ff [3];
   logic [UW-1:0]   qe_num_in [3];
   logic [PT_W-1:0] qe_quo_ff [3];
   logic [PT_W-1:0] qe_quo_in [3];
   logic [EPW-1:0]  est_prod [3];

   // remainder of the estimate
   logic            rm_valid_ff, rm_valid_in;
   logic            rm_brk_ff, rm_brk_in;
   logic            rm_last_ff, rm_last_in;
   logic            rm_hi_ff [3];
   logic            rm_hi_in [3];
   logic            rm_lo_ff [3];
   logic            rm_lo_in [3];
   logic [UW-1:0]   rm_rem_ff [3];
   logic [UW-1:0]   rm_rem_in [3];
   logic [PT_W-1:0] rm_quo_ff [3];
   logic [PT_W-1:0] rm_quo_in [3];

   // output register
   logic            out_valid_ff, out_valid_in;
   logic            out_brk_ff, out_brk_in;
   logic            out_last_ff, out_last_in;
   coord_type       out_ff [3];
   coord_type       out_in [3];
   logic [PT_W-1:0] quo_fix [3];

   assign adv = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      k_end = (k_ff == K_LAST);
      pop   = !qstat.empty && (!seg_valid_ff || (adv && !brk_pend_ff && k_end));

      seg_valid_in = seg_valid_ff;
      brk_pend_in  = brk_pend_ff;
      seg_last_in  = seg_last_ff;
      k_in         = k_ff;
      if (adv && seg_valid_ff) begin
         if (brk_pend_ff) begin
            brk_pend_in = 1'b0;
         end else if (k_end) begin
            seg_valid_in = 1'b0;
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
      if (pop) begin
         seg_valid_in = 1'b1;
         brk_pend_in  = head.brk;
         seg_last_in  = head.last;
         k_in         = '0;
      end

      for (int a = 0; a < 3; a++) begin
         d1[a] = (PT_W+1)'(pick(head.p3, a)) - (PT_W+1)'(pick(head.p1, a));
         d2[a] = (PT_W+1)'(pick(head.p2, a)) - (PT_W+1)'(pick(head.p4, a));
         if (pop) begin
            p2_in[a] = pick(head.p2, a);
            p3_in[a] = pick(head.p3, a);
            c1_in[a] = (CTRL_W'(pick(head.p2, a)) <<< 8)
                     + CTRL_W'(signed'({1'b0, tension})) * CTRL_W'(d1[a]);
            c2_in[a] = (CTRL_W'(pick(head.p3, a)) <<< 8)
                     + CTRL_W'(signed'({1'b0, tension})) * CTRL_W'(d2[a]);
         end else begin
            p2_in[a] = p2_ff[a];
            p3_in[a] = p3_ff[a];
            c1_in[a] = c1_ff[a];
            c2_in[a] = c2_ff[a];
         end
      end
   end

   always_comb begin
      s1_valid_in = seg_valid_ff;
      s1_brk_in   = brk_pend_ff;
      s1_last_in  = !brk_pend_ff && k_end && seg_last_ff;
      for (int a = 0; a < 3; a++) begin
         m1_in[a] = PW'(signed'({1'b0, w1_rom[k_ff]})) * PW'(p2_ff[a]);
         m4_in[a] = PW'(signed'({1'b0, w4_rom[k_ff]})) * PW'(p3_ff[a]);
         m2_in[a] = PW'(signed'({1'b0, w2_rom[k_ff]})) * PW'(c1_ff[a]);
         m3_in[a] = PW'(signed'({1'b0, w3_rom[k_ff]})) * PW'(c2_ff[a]);
      end
   end

   // the two end-point terms are at scale 2^8, the control terms at 2^16
   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_brk_in   = s1_brk_ff;
      s2_last_in  = s1_last_ff;
      for (int a = 0; a < 3; a++) begin
         tot[a] = ((NW'(m1_ff[a]) + NW'(m4_ff[a])) <<< 8)
                + NW'(m2_ff[a]) + NW'(m3_ff[a]) + HALF;
         sum_in[a] = tot[a] >>> 8;
      end
   end

   always_comb begin
      rc_valid_in = s2_valid_ff;
      rc_brk_in   = s2_brk_ff;
      rc_last_in  = s2_last_ff;
      for (int a = 0; a < 3; a++) begin
         rc_hi_in[a]  = (sum_ff[a] >= SPAN);
         rc_lo_in[a]  = (sum_ff[a] < NEG_SPAN);
         rc_num_in[a] = UW'(sum_ff[a] + SPAN);
      end
   end

   always_comb begin
      qe_valid_in = rc_valid_ff;
      qe_brk_in   = rc_brk_ff;
      qe_last_in  = rc_last_ff;
      for (int a = 0; a < 3; a++) begin
         qe_hi_in[a]  = rc_hi_ff[a];
         qe_lo_in[a]  = rc_lo_ff[a];
         qe_num_in[a] = rc_num_ff[a];
         est_prod[a]  = EPW'(rc_num_ff[a][UW-1:TSH]) * EPW'(RECIP);
         qe_quo_in[a] = est_prod[a][PSH +: PT_W];
      end
   end

   always_comb begin
      rm_valid_in = qe_valid_ff;
      rm_brk_in   = qe_brk_ff;
      rm_last_in  = qe_last_ff;
      for (int a = 0; a < 3; a++) begin
         rm_hi_in[a]  = qe_hi_ff[a];
         rm_lo_in[a]  = qe_lo_ff[a];
         rm_quo_in[a] = qe_quo_ff[a];
         rm_rem_in[a] = qe_num_ff[a] - UW'(qe_quo_ff[a]) * D3_U;
      end
   end

   // quotient is offset by 2^23, so flipping its top bit gives the signed result
   always_comb begin
      out_valid_in = adv ? rm_valid_ff : out_valid_ff;
      out_brk_in   = adv ? rm_brk_ff : out_brk_ff;
      out_last_in  = adv ? rm_last_ff : out_last_ff;
      for (int a = 0; a < 3; a++) begin
         quo_fix[a] = rm_quo_ff[a] + PT_W'(rm_rem_ff[a] >= D3_U);
         if (!adv) begin
            out_in[a] = out_ff[a];
         end else if (rm_brk_ff) begin
            out_in[a] = '0;
         end else if (rm_hi_ff[a]) begin
            out_in[a] = PT_MAX;
         end else if (rm_lo_ff[a]) begin
            out_in[a] = PT_MIN;
         end else begin
            out_in[a] = {~quo_fix[a][PT_W-1], quo_fix[a][PT_W-2:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_valid_ff <= 1'b0;
         brk_pend_ff  <= 1'b0;
         k_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rc_valid_ff  <= 1'b0;
         qe_valid_ff  <= 1'b0;
         rm_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         seg_valid_ff <= seg_valid_in;
         brk_pend_ff  <= brk_pend_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
         if (adv) begin
            s1_valid_ff <= s1_valid_in;
            s2_valid_ff <= s2_valid_in;
            rc_valid_ff <= rc_valid_in;
            qe_valid_ff <= qe_valid_in;
            rm_valid_ff <= rm_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      seg_last_ff <= seg_last_in;
      out_brk_ff  <= out_brk_in;
      out_last_ff <= out_last_in;
      for (int a = 0; a < 3; a++) begin
         p2_ff[a]  <= p2_in[a];
         p3_ff[a]  <= p3_in[a];
         c1_ff[a]  <= c1_in[a];
         c2_ff[a]  <= c2_in[a];
         out_ff[a] <= out_in[a];
      end
      if (adv) begin
         s1_brk_ff  <= s1_brk_in;
         s1_last_ff <= s1_last_in;
         s2_brk_ff  <= s2_brk_in;
         s2_last_ff <= s2_last_in;
         rc_brk_ff  <= rc_brk_in;
         rc_last_ff <= rc_last_in;
         qe_brk_ff  <= qe_brk_in;
         qe_last_ff <= qe_last_in;
         rm_brk_ff  <= rm_brk_in;
         rm_last_ff <= rm_last_in;
         for (int a = 0; a < 3; a++) begin
            m1_ff[a]     <= m1_in[a];
            m2_ff[a]     <= m2_in[a];
            m3_ff[a]     <= m3_in[a];
            m4_ff[a]     <= m4_in[a];
            sum_ff[a]    <= sum_in[a];
            rc_hi_ff[a]  <= rc_hi_in[a];
            rc_lo_ff[a]  <= rc_lo_in[a];
            rc_num_ff[a] <= rc_num_in[a];
            qe_hi_ff[a]  <= qe_hi_in[a];
            qe_lo_ff[a]  <= qe_lo_in[a];
            qe_num_ff[a] <= qe_num_in[a];
            qe_quo_ff[a] <= qe_quo_in[a];
            rm_hi_ff[a]  <= rm_hi_in[a];
            rm_lo_ff[a]  <= rm_lo_in[a];
            rm_rem_ff[a] <= rm_rem_in[a];
            rm_quo_ff[a] <= rm_quo_in[a];
         end
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.out_x    = out_ff[0];
   assign rsp_chan.out_y    = out_ff[1];
   assign rsp_chan.out_z    = out_ff[2];
   assign rsp_chan.is_break = out_brk_ff;
   assign rsp_chan.last     = out_last_ff;

endmodule

// File: sv/cubic_spline_tessellator.sv
`timescale 1ns / 1ps
// channel   dir   handshake      payload
// req_chan  in    valid/ready    x, y, z (q16.8), strand_end
// rsp_chan  out   valid/ready    out_x, out_y, out_z (q16.8), is_break, last
// csr_chan  in    valid/ready    data = tension (256ths), always ready
//
// one curve point per cycle from the back end unless rsp_chan stalls or no
// segment is queued; an ordinary point gives DOTS points, plus a strand's
// break marker and DOTS more for a strand end. inputs pass queue, issue,
// product, sum, range check, reciprocal estimate, remainder and output.
// synchronous reset clears history, queue pointers and pipeline valids;
// tension returns to 102. a stalled result freezes the whole back pipeline,
// the 4-entry segment queue lets the front keep taking points meanwhile.
module cubic_spline_tessellator import cst_pkg::*; #(
   parameter int DOTS        = DOTS_DEF,
   parameter int QUEUE_DEPTH = QDEPTH
) (
   input logic       clock,
   input logic       reset,
   cst_req_if.sink   req_chan,
   cst_rsp_if.source rsp_chan,
   cst_csr_if.sink   csr_chan
);

   logic [TEN_W-1:0] tension_ff, tension_in;
   logic             push, pop;
   seg_type          push_seg, head;
   qstat_type        qstat;

   assign csr_chan.ready = 1'b1;
   assign tension_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.data : tension_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tension_ff <= TEN_RESET;
      end else begin
         tension_ff <= tension_in;
      end
   end

   cst_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .qstat    (qstat),
      .push     (push),
      .push_seg (push_seg)
   );

   cst_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_seg),
      .pop       (pop),
      .pop_data  (head),
      .qstat     (qstat)
   );

   cst_back #(.DOTS(DOTS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .tension  (tension_ff),
      .head     (head),
      .qstat    (qstat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("segment queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("segment queue read while empty");

   a_break_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.is_break |->
         !rsp_chan.last && rsp_chan.out_x == '0 && rsp_chan.out_y == '0
         && rsp_chan.out_z == '0)
      else $error("break marker with coordinates or last set");

endmodule
